// ===== sv/pcm_pkg.sv =====
// Shared types, constants and tables of the peak compressor with mix.
package pcm_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int COEF_BITS     = 24;
    localparam int THR_BITS      = 15;
    localparam int WET_BITS      = 17;
    localparam int GAIN_BITS     = 25;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 24;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE   = 25'd16777216;
    localparam logic [18:0]          DB_PER_OCT = 19'd394566;
    localparam logic [21:0]          OCT_PER_DB = 22'd2786635;
    localparam logic [14:0]          SMOOTH_K   = 15'd16777;
    localparam logic [WET_BITS-1:0]  WET_FULL   = 17'd65536;

    localparam logic signed [THR_BITS-1:0] THR_RESET     = -15'sd6144;
    localparam logic [COEF_BITS-1:0]       SLOPE_RESET   = 24'd12582912;
    localparam logic [COEF_BITS-1:0]       ATTACK_RESET  = 24'd16742300;
    localparam logic [COEF_BITS-1:0]       RELEASE_RESET = 24'd16775468;
    localparam logic [WET_BITS-1:0]        WET_RESET     = 17'd22938;

    typedef logic signed [SAMPLE_BITS-1:0] t_sample;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_THRESHOLD = 3'd0,
        CFG_SLOPE     = 3'd1,
        CFG_ATTACK    = 3'd2,
        CFG_RELEASE   = 3'd3,
        CFG_WET       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic signed [THR_BITS-1:0] threshold_db;
        logic [COEF_BITS-1:0]       compression_slope;
        logic [COEF_BITS-1:0]       attack_coeff;
        logic [COEF_BITS-1:0]       release_coeff;
        logic [WET_BITS-1:0]        wet_level;
    } t_cfg;

    typedef enum logic [4:0] {
        S_IDLE, S_ENV_A, S_ENV_B, S_NORM, S_SQ, S_ATT, S_DB, S_OVER, S_RED, S_OCT,
        S_EXP, S_EXP_FIN, S_SMOOTH, S_WET_L, S_WET_R, S_MIX_LA, S_MIX_LB,
        S_MIX_RA, S_MIX_RB, S_DONE
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_ENV_A, OP_ENV_B, OP_NORM, OP_SQ, OP_ATT, OP_DB, OP_OVER,
        OP_RED, OP_OCT, OP_EXP, OP_EXP_FIN, OP_SMOOTH, OP_WET_L, OP_WET_R,
        OP_MIX_LA, OP_MIX_LB, OP_MIX_RA, OP_MIX_RB, OP_OUT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] step;
    } t_cmd;

    typedef struct packed {
        logic env_zero;
        logic over_pos;
    } t_stat;

    // 2^(-2^-(k+1)) in Q0.30
    function automatic logic [29:0] exp_factor(input logic [3:0] k);
        logic [29:0] f;
        unique case (k)
            4'd0:  f = 30'd759250125;
            4'd1:  f = 30'd902905651;
            4'd2:  f = 30'd984625594;
            4'd3:  f = 30'd1028218693;
            4'd4:  f = 30'd1050733751;
            4'd5:  f = 30'd1062175491;
            4'd6:  f = 30'd1067942999;
            4'd7:  f = 30'd1070838486;
            4'd8:  f = 30'd1072289172;
            4'd9:  f = 30'd1073015252;
            4'd10: f = 30'd1073378477;
            4'd11: f = 30'd1073560135;
            4'd12: f = 30'd1073650976;
            4'd13: f = 30'd1073696399;
            4'd14: f = 30'd1073719111;
            4'd15: f = 30'd1073730468;
        endcase
        return f;
    endfunction

endpackage

// ===== sv/pcm_in_if.sv =====
// Input channel: one stereo frame of dry and wet samples.
interface pcm_in_if;
    import pcm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample dry_left;
    t_sample dry_right;
    t_sample wet_left;
    t_sample wet_right;

    modport source (output valid, output dry_left, output dry_right,
                    output wet_left, output wet_right, input ready);
    modport sink   (input valid, input dry_left, input dry_right,
                    input wet_left, input wet_right, output ready);
endinterface

// ===== sv/pcm_out_if.sv =====
// Output channel: one mixed stereo frame.
interface pcm_out_if;
    import pcm_pkg::*;

    logic    valid;
    logic    ready;
    t_sample out_left;
    t_sample out_right;

    modport source (output valid, output out_left, output out_right, input ready);
    modport sink   (input valid, input out_left, input out_right, output ready);
endinterface

// ===== sv/peak_compressor_with_mix.sv =====
// Top level of the feed-forward peak compressor with dry/wet mix.
// One stereo frame goes in, one mixed frame comes out. A frame runs the log2 and
// the exponential when the envelope is above threshold, only the log2 when it is
// at or below threshold, and neither when the envelope is zero; the next frame
// is taken once the result is in the output register. One shared 33x33
// multiplier runs a 16-step log2 (mantissa squaring) and a 16-step
// exponential (factor product). The result sits in an output register, so a
// new frame is taken while the previous result still waits for transfer.
// Write configuration only while the block is idle.
module peak_compressor_with_mix (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    pcm_in_if.sink                              i_in,
    pcm_out_if.source                           o_out,
    input  logic                                i_cfg_we,
    input  logic [pcm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [pcm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    import pcm_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    pcm_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    pcm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pcm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_dry_left  (i_in.dry_left),
        .i_dry_right (i_in.dry_right),
        .i_wet_left  (i_in.wet_left),
        .i_wet_right (i_in.wet_right),
        .o_stat      (stat),
        .o_out_left  (o_out.out_left),
        .o_out_right (o_out.out_right)
    );
endmodule

// ===== sv/pcm_regs.sv =====
// Configuration register file of the compressor.
module pcm_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcm_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [pcm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    output pcm_pkg::t_cfg                       o_cfg
);
    import pcm_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_THRESHOLD: n_cfg.threshold_db      = i_cfg_data[THR_BITS-1:0];
                CFG_SLOPE:     n_cfg.compression_slope = i_cfg_data[COEF_BITS-1:0];
                CFG_ATTACK:    n_cfg.attack_coeff      = i_cfg_data[COEF_BITS-1:0];
                CFG_RELEASE:   n_cfg.release_coeff     = i_cfg_data[COEF_BITS-1:0];
                CFG_WET:       n_cfg.wet_level         = i_cfg_data[WET_BITS-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold_db      <= THR_RESET;
            r_cfg.compression_slope <= SLOPE_RESET;
            r_cfg.attack_coeff      <= ATTACK_RESET;
            r_cfg.release_coeff     <= RELEASE_RESET;
            r_cfg.wet_level         <= WET_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ===== sv/pcm_ctrl.sv =====
// Sequencer that steps the datapath through one frame.
module pcm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  pcm_pkg::t_stat  i_stat,
    output pcm_pkg::t_cmd   o_cmd
);
    import pcm_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic       r_out_valid, n_out_valid;
    logic       slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (i_in_valid) n_state = S_ENV_A;
            S_ENV_A:   n_state = S_ENV_B;
            S_ENV_B:   n_state = S_NORM;
            S_NORM:    n_state = i_stat.env_zero ? S_SMOOTH : S_SQ;
            S_SQ:      if (r_cnt == 4'd15) n_state = S_ATT;
            S_ATT:     n_state = S_DB;
            S_DB:      n_state = S_OVER;
            S_OVER:    n_state = i_stat.over_pos ? S_RED : S_SMOOTH;
            S_RED:     n_state = S_OCT;
            S_OCT:     n_state = S_EXP;
            S_EXP:     if (r_cnt == 4'd15) n_state = S_EXP_FIN;
            S_EXP_FIN: n_state = S_SMOOTH;
            S_SMOOTH:  n_state = S_WET_L;
            S_WET_L:   n_state = S_WET_R;
            S_WET_R:   n_state = S_MIX_LA;
            S_MIX_LA:  n_state = S_MIX_LB;
            S_MIX_LB:  n_state = S_MIX_RA;
            S_MIX_RA:  n_state = S_MIX_RB;
            S_MIX_RB:  n_state = S_DONE;
            S_DONE:    if (slot_free) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.step  = r_cnt;
        o_cmd.op    = OP_NONE;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_cmd.op = OP_LOAD;
            end
            S_ENV_A:   o_cmd.op = OP_ENV_A;
            S_ENV_B:   o_cmd.op = OP_ENV_B;
            S_NORM:    o_cmd.op = OP_NORM;
            S_SQ:      o_cmd.op = OP_SQ;
            S_ATT:     o_cmd.op = OP_ATT;
            S_DB:      o_cmd.op = OP_DB;
            S_OVER:    o_cmd.op = OP_OVER;
            S_RED:     o_cmd.op = OP_RED;
            S_OCT:     o_cmd.op = OP_OCT;
            S_EXP:     o_cmd.op = OP_EXP;
            S_EXP_FIN: o_cmd.op = OP_EXP_FIN;
            S_SMOOTH:  o_cmd.op = OP_SMOOTH;
            S_WET_L:   o_cmd.op = OP_WET_L;
            S_WET_R:   o_cmd.op = OP_WET_R;
            S_MIX_LA:  o_cmd.op = OP_MIX_LA;
            S_MIX_LB:  o_cmd.op = OP_MIX_LB;
            S_MIX_RA:  o_cmd.op = OP_MIX_RA;
            S_MIX_RB:  o_cmd.op = OP_MIX_RB;
            S_DONE:    if (slot_free) o_cmd.op = OP_OUT;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_state == S_NORM || r_state == S_OCT) begin
            n_cnt = 4'd0;
        end else if (r_state == S_SQ || r_state == S_EXP) begin
            n_cnt = r_cnt + 4'd1;
        end
        n_out_valid = (r_out_valid && !i_out_ready) || (r_state == S_DONE && slot_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 4'd0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
endmodule

// ===== sv/pcm_dp.sv =====
// Datapath: envelope, log/exp gain computer and mix on one shared multiplier.
module pcm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pcm_pkg::t_cmd     i_cmd,
    input  pcm_pkg::t_cfg     i_cfg,
    input  pcm_pkg::t_sample  i_dry_left,
    input  pcm_pkg::t_sample  i_dry_right,
    input  pcm_pkg::t_sample  i_wet_left,
    input  pcm_pkg::t_sample  i_wet_right,
    output pcm_pkg::t_stat    o_stat,
    output pcm_pkg::t_sample  o_out_left,
    output pcm_pkg::t_sample  o_out_right
);
    import pcm_pkg::*;

    // frame samples
    t_sample r_dl, r_dr, r_wl, r_wr;
    // state
    logic [23:0] r_env, n_env;
    logic [24:0] r_gain, n_gain;
    // work registers
    logic signed [48:0] r_acc, n_acc;
    logic [30:0] r_m, n_m;
    logic [15:0] r_frac, n_frac;
    logic [4:0]  r_p, n_p;
    logic [23:0] r_l, n_l;
    logic [24:0] r_target, n_target;
    logic signed [24:0] r_wetl, n_wetl, r_wetr, n_wetr;
    t_sample r_mixl, n_mixl, r_mixr, n_mixr;
    t_sample r_outl, r_outr;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod;

    logic [23:0] mag_l, mag_r, peak, coef, wmag, wsel;
    logic [24:0] cbar, diff;
    logic        up;
    logic [16:0] w_eff, w_dry;
    logic [4:0]  lead;
    logic [31:0] sq;
    logic [20:0] att;
    logic [47:0] t_round;
    logic [48:0] env_sum;
    logic signed [26:0] over;
    logic [31:0] shifted;
    logic signed [48:0] mix_sum;
    logic [48:0] mix_mag, mix_rnd;
    logic [32:0] rnd;
    t_sample sat;
    logic right_ch;
    t_sample dsel;
    logic signed [24:0] wetsel;

    assign mag_l = r_dl[23] ? 24'(~r_dl + 24'd1) : r_dl;
    assign mag_r = r_dr[23] ? 24'(~r_dr + 24'd1) : r_dr;
    assign peak  = (mag_l > mag_r) ? mag_l : mag_r;
    assign coef  = (peak > r_env) ? i_cfg.attack_coeff : i_cfg.release_coeff;
    assign cbar  = GAIN_ONE - {1'b0, coef};
    assign w_eff = (i_cfg.wet_level > WET_FULL) ? WET_FULL : i_cfg.wet_level;
    assign w_dry = WET_FULL - w_eff;
    assign up    = (r_target >= r_gain);
    assign diff  = up ? (r_target - r_gain) : (r_gain - r_target);

    assign right_ch = (i_cmd.op == OP_WET_R) || (i_cmd.op == OP_MIX_RA) ||
                      (i_cmd.op == OP_MIX_RB);
    assign wsel   = right_ch ? r_wr : r_wl;
    assign wmag   = wsel[23] ? 24'(~wsel + 24'd1) : wsel;
    assign dsel   = right_ch ? r_dr : r_dl;
    assign wetsel = right_ch ? r_wetr : r_wetl;

    always_comb begin
        lead = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (r_env[i]) lead = 5'(i);
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        unique case (i_cmd.op)
            OP_ENV_A: begin
                mul_a = {9'b0, coef};
                mul_b = {9'b0, r_env};
            end
            OP_ENV_B: begin
                mul_a = {8'b0, cbar};
                mul_b = {9'b0, peak};
            end
            OP_SQ: begin
                mul_a = {2'b0, r_m};
                mul_b = {2'b0, r_m};
            end
            OP_DB: begin
                mul_a = r_acc[32:0];
                mul_b = {14'b0, DB_PER_OCT};
            end
            OP_RED: begin
                mul_a = r_acc[32:0];
                mul_b = {9'b0, i_cfg.compression_slope};
            end
            OP_OCT: begin
                mul_a = r_acc[32:0];
                mul_b = {11'b0, OCT_PER_DB};
            end
            OP_EXP: begin
                mul_a = {2'b0, r_m};
                mul_b = {3'b0, exp_factor(i_cmd.step)};
            end
            OP_SMOOTH: begin
                mul_a = {8'b0, diff};
                mul_b = {18'b0, SMOOTH_K};
            end
            OP_WET_L, OP_WET_R: begin
                mul_a = {9'b0, wmag};
                mul_b = {8'b0, r_gain};
            end
            OP_MIX_LA, OP_MIX_RA: begin
                mul_a = {{9{dsel[23]}}, dsel};
                mul_b = {16'b0, w_dry};
            end
            OP_MIX_LB, OP_MIX_RB: begin
                mul_a = {{8{wetsel[24]}}, wetsel};
                mul_b = {16'b0, w_eff};
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    assign env_sum = {1'b0, r_acc[47:0]} + prod[48:0] + 49'd8388608;
    assign sq      = prod[61:30];
    assign att     = (r_p >= 5'd23) ? 21'd0 : ({(5'd23 - r_p), 16'b0} - {5'b0, r_frac});
    assign over    = 27'sd0 - $signed({3'b0, r_acc[23:0]})
                     - $signed({{4{i_cfg.threshold_db[14]}}, i_cfg.threshold_db, 8'b0});
    assign shifted = {1'b0, (r_m >> r_l[20:16])} + 32'd32;
    assign mix_sum = r_acc + $signed(prod[48:0]);
    assign mix_mag = mix_sum[48] ? 49'(-mix_sum) : mix_sum;
    assign mix_rnd = mix_mag + 49'd32768;
    assign rnd     = mix_rnd[48:16];

    always_comb begin
        t_round = 48'd0;
        unique case (i_cmd.op)
            OP_DB:                                  t_round = prod[47:0] + 48'd32768;
            OP_RED, OP_OCT, OP_SMOOTH,
            OP_WET_L, OP_WET_R:                     t_round = prod[47:0] + 48'd8388608;
            default:                                t_round = 48'd0;
        endcase
    end

    // saturate the rounded mix to the sample range
    always_comb begin
        if (mix_sum[48]) begin
            sat = (rnd > 33'd8388608) ? 24'sh800000 : t_sample'(24'd0 - rnd[23:0]);
        end else begin
            sat = (rnd > 33'd8388607) ? 24'sh7fffff : t_sample'(rnd[23:0]);
        end
    end

    always_comb begin
        n_env    = r_env;
        n_gain   = r_gain;
        n_acc    = r_acc;
        n_m      = r_m;
        n_frac   = r_frac;
        n_p      = r_p;
        n_l      = r_l;
        n_target = r_target;
        n_wetl   = r_wetl;
        n_wetr   = r_wetr;
        n_mixl   = r_mixl;
        n_mixr   = r_mixr;
        unique case (i_cmd.op)
            OP_ENV_A: n_acc = prod[48:0];
            OP_ENV_B: n_env = env_sum[47:24];
            OP_NORM: begin
                n_p    = lead;
                n_m    = {7'b0, r_env} << (5'd30 - lead);
                n_frac = 16'd0;
                if (r_env == 24'd0) n_target = GAIN_ONE;
            end
            OP_SQ: begin
                if (sq[31]) begin
                    n_m    = sq[31:1];
                    n_frac = {r_frac[14:0], 1'b1};
                end else begin
                    n_m    = sq[30:0];
                    n_frac = {r_frac[14:0], 1'b0};
                end
            end
            OP_ATT:  n_acc = {28'b0, att};
            OP_DB:   n_acc = {25'b0, t_round[39:16]};
            OP_OVER: begin
                n_acc = {{22{over[26]}}, over};
                if (!(over > 27'sd0)) n_target = GAIN_ONE;
            end
            OP_RED:  n_acc = {25'b0, t_round[47:24]};
            OP_OCT: begin
                n_l = t_round[47:24];
                n_m = 31'd1073741824;
            end
            OP_EXP: begin
                if (r_l[4'd15 - i_cmd.step]) n_m = 31'((prod[60:0] + 61'd536870912) >> 30);
            end
            OP_EXP_FIN: n_target = (r_l[23:16] >= 8'd31) ? 25'd0 : shifted[30:6];
            OP_SMOOTH:  n_gain = up ? (r_gain + {9'b0, t_round[39:24]})
                                    : (r_gain - {9'b0, t_round[39:24]});
            OP_WET_L:   n_wetl = wsel[23] ? (25'sd0 - $signed({1'b0, t_round[47:24]}))
                                          : $signed({1'b0, t_round[47:24]});
            OP_WET_R:   n_wetr = wsel[23] ? (25'sd0 - $signed({1'b0, t_round[47:24]}))
                                          : $signed({1'b0, t_round[47:24]});
            OP_MIX_LA, OP_MIX_RA: n_acc = $signed(prod[48:0]);
            OP_MIX_LB: n_mixl = sat;
            OP_MIX_RB: n_mixr = sat;
            default: ;
        endcase
    end

    assign o_stat.env_zero = (r_env == 24'd0);
    assign o_stat.over_pos = (over > 27'sd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_env  <= 24'd0;
            r_gain <= GAIN_ONE;
        end else begin
            r_env  <= n_env;
            r_gain <= n_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_m      <= n_m;
        r_frac   <= n_frac;
        r_p      <= n_p;
        r_l      <= n_l;
        r_target <= n_target;
        r_wetl   <= n_wetl;
        r_wetr   <= n_wetr;
        r_mixl   <= n_mixl;
        r_mixr   <= n_mixr;
        if (i_cmd.op == OP_LOAD) begin
            r_dl <= i_dry_left;
            r_dr <= i_dry_right;
            r_wl <= i_wet_left;
            r_wr <= i_wet_right;
        end
        if (i_cmd.op == OP_OUT) begin
            r_outl <= r_mixl;
            r_outr <= r_mixr;
        end
    end

    assign o_out_left  = r_outl;
    assign o_out_right = r_outr;
endmodule

// ===== tb/pcm_checker.sv =====
// Checker for the peak compressor: predicts each mixed frame and compares it.
`timescale 1ns / 1ps
module pcm_checker
    import pcm_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    pcm_in_if            i_in,
    pcm_out_if           i_out,
    input  logic         i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int           o_errors,
    output int           o_pending
);

    typedef struct packed {
        t_sample left;
        t_sample right;
    } t_frame;

    t_frame mix_q[$];

    logic signed [THR_BITS-1:0] thr;
    logic [COEF_BITS-1:0] slope, att_c, rel_c;
    logic [WET_BITS-1:0]  wet_lvl;
    logic [63:0] env;
    logic [63:0] gain;

    localparam logic [63:0] DB_OCT  = 64'd394566;
    localparam logic [63:0] OCT_DB  = 64'd2786635;
    localparam logic [63:0] K_SMTH  = 64'd16777;

    function automatic logic [63:0] factor(input int k);
        case (k)
            0:  return 64'd759250125;
            1:  return 64'd902905651;
            2:  return 64'd984625594;
            3:  return 64'd1028218693;
            4:  return 64'd1050733751;
            5:  return 64'd1062175491;
            6:  return 64'd1067942999;
            7:  return 64'd1070838486;
            8:  return 64'd1072289172;
            9:  return 64'd1073015252;
            10: return 64'd1073378477;
            11: return 64'd1073560135;
            12: return 64'd1073650976;
            13: return 64'd1073696399;
            14: return 64'd1073719111;
            default: return 64'd1073730468;
        endcase
    endfunction

    function automatic longint rnd_shift(input longint x, input int sh);
        longint h;
        h = longint'(1) << (sh - 1);
        if (x >= 0) return (x + h) >>> sh;
        return -((-x + h) >>> sh);
    endfunction

    // -log2(e / full scale) in Q.16
    function automatic logic [63:0] atten_log2(input logic [63:0] e);
        int p;
        logic [63:0] m, frac;
        p = 0;
        frac = 0;
        for (int i = 0; i < 64; i++) if (e[i]) p = i;
        m = (p <= 30) ? (e << (30 - p)) : (e >> (p - 30));
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac = frac | 1;
            end
        end
        if (p >= SAMPLE_BITS - 1) return 0;
        return 64'(SAMPLE_BITS - 1 - p) * 65536 - frac;
    endfunction

    function automatic logic [63:0] pow2_neg(input logic [63:0] l);
        logic [63:0] n, g;
        n = l >> 16;
        g = 64'd1 << 30;
        for (int k = 0; k < 16; k++)
            if (l[15 - k]) g = (g * factor(k) + (64'd1 << 29)) >> 30;
        if (n >= 31) return 0;
        return ((g >> n) + 32) >> 6;
    endfunction

    function automatic t_frame compress_frame(input t_sample dl, input t_sample dr,
                                              input t_sample wl, input t_sample wr);
        logic [63:0] pk, ml, mr, c, tgt, e, r, l, w;
        longint over, v, lo, hi, wt, dry_s, wet_s;
        t_frame f;
        ml = (dl < 0) ? 64'(-longint'(dl)) : 64'(longint'(dl));
        mr = (dr < 0) ? 64'(-longint'(dr)) : 64'(longint'(dr));
        pk = (ml > mr) ? ml : mr;
        c = (pk > env) ? 64'(att_c) : 64'(rel_c);
        env = (c * env + ((64'd1 << COEF_BITS) - c) * pk + (64'd1 << (COEF_BITS - 1)))
              >> COEF_BITS;
        tgt = 64'(GAIN_ONE);
        if (env > 0) begin
            e = (atten_log2(env) * DB_OCT + 32768) >> 16;
            over = -longint'(e) - longint'(thr) * 256;
            if (over > 0) begin
                r = (64'(over) * 64'(slope) + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;
                l = (r * OCT_DB + (64'd1 << 23)) >> 24;
                tgt = pow2_neg(l);
            end
        end
        if (tgt >= gain) gain = gain + (((tgt - gain) * K_SMTH + (64'd1 << 23)) >> 24);
        else gain = gain - (((gain - tgt) * K_SMTH + (64'd1 << 23)) >> 24);
        w = (wet_lvl > 65536) ? 64'd65536 : 64'(wet_lvl);
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        lo = -hi - 1;
        for (int ch = 0; ch < 2; ch++) begin
            dry_s = longint'(ch == 0 ? dl : dr);
            wt = longint'(ch == 0 ? wl : wr);
            wet_s = rnd_shift(wt * longint'(gain), 24);
            v = rnd_shift(dry_s * longint'(65536 - w) + wet_s * longint'(w), 16);
            if (v > hi) v = hi;
            if (v < lo) v = lo;
            if (ch == 0) f.left = t_sample'(v);
            else f.right = t_sample'(v);
        end
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_frame want;
        t_frame got;
        if (!i_rst_n) begin
            thr <= THR_RESET;
            slope <= SLOPE_RESET;
            att_c <= ATTACK_RESET;
            rel_c <= RELEASE_RESET;
            wet_lvl <= WET_RESET;
            env = 0;
            gain = 64'(GAIN_ONE);
            mix_q.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_THRESHOLD: thr <= i_cfg_data[THR_BITS-1:0];
                    CFG_SLOPE:     slope <= i_cfg_data[COEF_BITS-1:0];
                    CFG_ATTACK:    att_c <= i_cfg_data[COEF_BITS-1:0];
                    CFG_RELEASE:   rel_c <= i_cfg_data[COEF_BITS-1:0];
                    CFG_WET:       wet_lvl <= i_cfg_data[WET_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                got = compress_frame(i_in.dry_left, i_in.dry_right,
                                     i_in.wet_left, i_in.wet_right);
                mix_q.insert(mix_q.size(), got);
            end
            if (i_out.valid && i_out.ready) begin
                if (mix_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected frame %0d %0d",
                                                i_out.out_left, i_out.out_right);
                    o_errors <= o_errors + 1;
                end else begin
                    want = mix_q.pop_front();
                    if (want.left !== i_out.out_left || want.right !== i_out.out_right) begin
                        if (o_errors < 10)
                            $display("mismatch: expected %0d %0d, got %0d %0d",
                                     want.left, want.right, i_out.out_left, i_out.out_right);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
        o_pending <= mix_q.size();
    end

endmodule

// ===== tb/peak_compressor_with_mix_tb.sv =====
// Testbench top: stimulus, configuration phases and verdict for the compressor.
`timescale 1ns / 1ps
module peak_compressor_with_mix_tb;
    import pcm_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;
    int   errors, pending;
    int   send_idle_pct, recv_stall_pct, hold_cycles;

    pcm_in_if  in_ch ();
    pcm_out_if out_ch ();

    peak_compressor_with_mix uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    pcm_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Receiver: random stall, or a long hold-off when requested.
    initial begin
        out_ch.ready = 0;
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                out_ch.ready <= 0;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_sample rand_sample(input int kind);
        case (kind)
            0: return t_sample'($urandom);
            1: return t_sample'($urandom_range(2000) - 1000);
            2: return t_sample'(24'h800000 + $urandom_range(100000));
            default: return t_sample'(24'h7FFFFF - $urandom_range(100000));
        endcase
    endfunction

    task automatic send_frame(input t_sample dl, input t_sample dr,
                              input t_sample wl, input t_sample wr);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.dry_left <= dl;
        in_ch.dry_right <= dr;
        in_ch.wet_left <= wl;
        in_ch.wet_right <= wr;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain();
        in_ch.valid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic random_burst(input int count);
        int kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(3);
            send_frame(rand_sample(kind), rand_sample($urandom_range(3)),
                       rand_sample(0), rand_sample($urandom_range(3)));
        end
    endtask

    initial begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        in_ch.valid = 0;
        in_ch.dry_left = '0;
        in_ch.dry_right = '0;
        in_ch.wet_left = '0;
        in_ch.wet_right = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: silence, full scale extremes, reset settings.
        send_frame(24'sd0, 24'sd0, 24'sd0, 24'sd0);
        send_frame(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_frame(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 24'sh800000);
        send_frame(24'sd1, -24'sd1, 24'sh7FFFFF, 24'sh800000);
        for (int i = 0; i < 6; i++)
            send_frame(24'sh800000, 24'sh800000, 24'sh800000, 24'sh7FFFFF);
        drain();

        // Extremes: fast poles, maximum slope, 0 dB threshold, full wet.
        write_reg(CFG_THRESHOLD, 24'(15'sd0));
        write_reg(CFG_SLOPE, 24'd15938355);
        write_reg(CFG_ATTACK, 24'd0);
        write_reg(CFG_RELEASE, 24'd0);
        write_reg(CFG_WET, 24'd65536);
        send_frame(24'sh7FFFFF, 24'sd0, 24'sh7FFFFF, 24'sh800000);
        send_frame(24'sd0, 24'sd0, 24'sh7FFFFF, 24'sh7FFFFF);
        drain();
        // Lowest threshold, wet level over one, slowest poles.
        write_reg(CFG_THRESHOLD, 24'(-15'sd15360));
        write_reg(CFG_WET, 24'h1FFFF);
        write_reg(CFG_ATTACK, 24'hFFFFFF);
        write_reg(CFG_RELEASE, 24'hFFFFFF);
        send_frame(24'sh800000, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
        send_frame(24'sd5, 24'sd3, 24'sh400000, -24'sh400000);
        drain();
        // Ignored index and an above-zero threshold.
        write_reg(t_cfg_idx'(3'd7), 24'hABCDEF);
        write_reg(CFG_THRESHOLD, 24'h3FFF);
        write_reg(CFG_WET, 24'd0);
        write_reg(CFG_SLOPE, 24'd0);
        send_frame(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        drain();

        // Random phases with idling patterns and settings.
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_THRESHOLD, 24'(15'($urandom_range(15360)) * -1));
            write_reg(CFG_SLOPE, 24'($urandom_range(15938355)));
            write_reg(CFG_ATTACK, (ph % 2) ? 24'($urandom)
                                           : 24'(24'd16777215 - $urandom_range(60000)));
            write_reg(CFG_RELEASE, (ph % 2) ? 24'($urandom)
                                            : 24'(24'd16777215 - $urandom_range(5000)));
            write_reg(CFG_WET, 24'($urandom_range(65536)));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            if (ph == 2) hold_cycles = 600;
            random_burst(72);
            drain();
        end

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== peak_compressor_with_mix.f =====
sv/pcm_pkg.sv
sv/pcm_in_if.sv
sv/pcm_out_if.sv
sv/pcm_regs.sv
sv/pcm_ctrl.sv
sv/pcm_dp.sv
sv/peak_compressor_with_mix.sv
tb/pcm_checker.sv
tb/peak_compressor_with_mix_tb.sv
